// File: src/dep_pkg.sv
// Shared types, sizes and codes for the distance event priority evaluator.
package dep_pkg;

  // Table sizes and distance width
  localparam int SINGLE_EVENTS   = 16;
  localparam int COMPOUND_EVENTS = 4;
  localparam int DIST_BITS       = 16;
  localparam int TOTAL_EVENTS    = SINGLE_EVENTS + COMPOUND_EVENTS;

  // Lane organization of the single table: entry e sits in lane e % LANES, row e / LANES
  localparam int LANES  = 4;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = (SINGLE_EVENTS + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W  = (COMPOUND_EVENTS > 1) ? $clog2(COMPOUND_EVENTS) : 1;
  localparam int SCAN_W = (ROW_W > CMP_W) ? ROW_W : CMP_W;
  localparam int EV_W   = $clog2(TOTAL_EVENTS);

  // Fixed field widths on the stream ports
  localparam int IDX_W    = 5;
  localparam int MM_W     = 16;
  localparam int STATUS_W = 20;
  localparam int IN_BITS  = 98;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + 1 + IDX_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int REF_W    = 1 << IDX_W;
  localparam int PAD_W    = (TOTAL_EVENTS > REF_W) ? TOTAL_EVENTS : REF_W;

  // Operation codes carried on tuser
  localparam logic [1:0] OP_WR_SINGLE   = 2'd0;
  localparam logic [1:0] OP_WR_COMPOUND = 2'd1;
  localparam logic [1:0] OP_EVAL        = 2'd2;

  // Sensor codes
  localparam logic [1:0] SENSOR_0 = 2'd0;
  localparam logic [1:0] SENSOR_1 = 2'd1;
  localparam logic [1:0] SENSOR_2 = 2'd2;

  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sensor;
    dist_t      lo;
    dist_t      hi;
  } single_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
  } compound_entry_t;

  // Sequencer controls for the merge stage
  typedef struct packed {
    logic             clear;
    logic             single_en;
    logic [ROW_W-1:0] row;
    logic             compound_en;
    logic [CMP_W-1:0] slot;
  } merge_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_COMPOUND,
    ST_FINISH
  } state_t;

endpackage

// File: src/dep_lane.sv
// One single-event lane: its bank of range entries and the range check of one row.
module dep_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [dep_pkg::ROW_W-1:0] wr_row,
  input  dep_pkg::single_entry_t wr_entry,
  input  logic [dep_pkg::ROW_W-1:0] rd_row,
  input  dep_pkg::dist_t        dist0,
  input  dep_pkg::dist_t        dist1,
  input  dep_pkg::dist_t        dist2,
  output logic                  hit
);
  import dep_pkg::*;

  single_entry_t bank [ROWS];
  single_entry_t cur;
  dist_t         d;
  logic          sensor_ok;

  // Bank write; only the enable bits need a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        bank[r].en <= 1'b0;
      end
    end else if (wr_en) begin
      bank[wr_row] <= wr_entry;
    end
  end

  // Sensor select and range check
  always_comb begin
    cur       = bank[rd_row];
    d         = '0;
    sensor_ok = 1'b1;
    case (cur.sensor)
      SENSOR_0: d = dist0;
      SENSOR_1: d = dist1;
      SENSOR_2: d = dist2;
      default:  sensor_ok = 1'b0;
    endcase
    hit = cur.en && sensor_ok && (d >= cur.lo) && (d <= cur.hi);
  end

endmodule

// File: src/dep_compound.sv
// Compound AND table and the check of one compound entry against the live flags.
module dep_compound (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [dep_pkg::CMP_W-1:0]     wr_slot,
  input  dep_pkg::compound_entry_t      wr_entry,
  input  logic [dep_pkg::CMP_W-1:0]     rd_slot,
  input  logic [dep_pkg::TOTAL_EVENTS-1:0] flags,
  output logic                          hit
);
  import dep_pkg::*;

  compound_entry_t tbl [COMPOUND_EVENTS];
  compound_entry_t cur;
  logic [PAD_W-1:0] flags_pad;
  logic [REF_W-1:0] ref_flags;

  // Table write; enable bits cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COMPOUND_EVENTS; c++) begin
        tbl[c].en <= 1'b0;
      end
    end else if (wr_en) begin
      tbl[wr_slot] <= wr_entry;
    end
  end

  // Event numbers past the table read as zero flags
  always_comb begin
    flags_pad = PAD_W'(flags);
    ref_flags = flags_pad[REF_W-1:0];
    cur       = tbl[rd_slot];
    hit       = cur.en && ref_flags[cur.first] && ref_flags[cur.second];
  end

endmodule

// File: src/dep_merge.sv
// Merge stage: collects lane and compound results into the event flags and top event.
module dep_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  dep_pkg::merge_ctl_t           ctl,
  input  logic [dep_pkg::LANES-1:0]     lane_hit,
  input  logic                          cmp_hit,
  output logic [dep_pkg::TOTAL_EVENTS-1:0] flags,
  output logic                          any,
  output logic [dep_pkg::EV_W-1:0]      top
);
  import dep_pkg::*;

  logic              row_found;
  logic [LANE_W-1:0] row_best;

  // Highest hitting lane of the current row
  always_comb begin
    row_found = 1'b0;
    row_best  = '0;
    for (int l = 0; l < LANES; l++) begin
      if (lane_hit[l]) begin
        row_found = 1'b1;
        row_best  = LANE_W'(l);
      end
    end
  end

  // Flags are updated in place, so later compounds keep their previous status
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      any   <= 1'b0;
      top   <= '0;
    end else begin
      if (ctl.clear) begin
        any <= 1'b0;
        top <= '0;
      end
      if (ctl.single_en) begin
        for (int i = 0; i < SINGLE_EVENTS; i++) begin
          if (ctl.row == ROW_W'(i / LANES)) begin
            flags[i] <= lane_hit[i % LANES];
          end
        end
        if (row_found) begin
          any <= 1'b1;
          top <= EV_W'({ctl.row, row_best});
        end
      end
      if (ctl.compound_en) begin
        for (int j = 0; j < COMPOUND_EVENTS; j++) begin
          if (ctl.slot == CMP_W'(j)) begin
            flags[SINGLE_EVENTS + j] <= cmp_hit;
          end
        end
        if (cmp_hit) begin
          any <= 1'b1;
          top <= EV_W'(SINGLE_EVENTS) + EV_W'(ctl.slot);
        end
      end
    end
  end

endmodule

// File: src/distance_event_priority_evaluator.sv
// Top level of the distance event priority evaluator: sequencer, lanes, merge, output register.
//
// Usage:
//   Input beats arrive on s_axis_*; tuser carries the operation (write single
//   entry, write compound entry, evaluate). Writes load one table entry and
//   give no output beat; a write to an index outside the matching table and
//   operation code 3 are dropped. An evaluate beat gives one output beat on
//   m_axis_* with the status flags, an any-active bit and the top event.
// Timing:
//   An evaluate walks the single table four lanes wide, one row per cycle,
//   then the compound chain one entry per cycle, then loads the output
//   register; no new beat is taken until the output register is loaded.
//   The compound chain is serial since each entry sees the lower ones.
// Reset:
//   rst clears every entry enable, all event flags and the output valid.
// Stall:
//   A waiting result stays in the output register while writes and a new
//   evaluate are accepted; an evaluate that finishes while the previous
//   result is still held waits in its last step until m_axis_tready.
module distance_event_priority_evaluator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // entry_index, entry_enable, entry_sensor, min_mm, max_mm, first_event,
  // second_event, dist_sensor0, dist_sensor1, dist_sensor2, zero fill
  input  logic [dep_pkg::IN_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status_bits, any_active, top_event, zero fill
  output logic [dep_pkg::OUT_W-1:0] m_axis_tdata
);
  import dep_pkg::*;

  // Input field unpacking
  logic [IDX_W-1:0] entry_index;
  logic             entry_enable;
  logic [1:0]       entry_sensor;
  logic [MM_W-1:0]  min_mm;
  logic [MM_W-1:0]  max_mm;
  logic [IDX_W-1:0] first_event;
  logic [IDX_W-1:0] second_event;
  logic [MM_W-1:0]  dist_sensor0;
  logic [MM_W-1:0]  dist_sensor1;
  logic [MM_W-1:0]  dist_sensor2;

  assign entry_index  = s_axis_tdata[4:0];
  assign entry_enable = s_axis_tdata[5];
  assign entry_sensor = s_axis_tdata[7:6];
  assign min_mm       = s_axis_tdata[23:8];
  assign max_mm       = s_axis_tdata[39:24];
  assign first_event  = s_axis_tdata[44:40];
  assign second_event = s_axis_tdata[49:45];
  assign dist_sensor0 = s_axis_tdata[65:50];
  assign dist_sensor1 = s_axis_tdata[81:66];
  assign dist_sensor2 = s_axis_tdata[97:82];

  state_t            state;
  state_t            state_next;
  logic [SCAN_W-1:0] scan;
  logic [SCAN_W-1:0] scan_next;
  dist_t             dist0;
  dist_t             dist1;
  dist_t             dist2;
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  logic              accept;
  logic              eval_start;
  logic              scan_single;
  logic              scan_compound;
  logic              out_free;
  logic              out_load;
  logic              single_last;
  logic              compound_last;

  logic                 wr_single;
  logic                 wr_compound;
  logic [LANE_W-1:0]    wr_lane;
  logic [ROW_W-1:0]     wr_row;
  logic [CMP_W-1:0]     wr_slot;
  single_entry_t        wr_single_entry;
  compound_entry_t      wr_cmp_entry;

  merge_ctl_t              mctl;
  logic [LANES-1:0]        lane_hit;
  logic                    cmp_hit;
  logic [TOTAL_EVENTS-1:0] flags;
  logic                    any;
  logic [EV_W-1:0]         top;
  logic [PAD_W-1:0]        flags_pad;

  // Handshake and step decode
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign single_last   = (scan == SCAN_W'(ROWS - 1));
  assign compound_last = (scan == SCAN_W'(COMPOUND_EVENTS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_axis_tuser == OP_EVAL)) begin
          state_next = ST_SINGLE;
        end
      end
      ST_SINGLE: begin
        if (single_last) begin
          state_next = ST_COMPOUND;
        end
      end
      ST_COMPOUND: begin
        if (compound_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    scan_single   = 1'b0;
    scan_compound = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_SINGLE:   scan_single   = 1'b1;
      ST_COMPOUND: scan_compound = 1'b1;
      ST_FINISH:   out_load      = out_free;
      default:     s_axis_tready = 1'b0;
    endcase
  end

  assign eval_start = accept && (s_axis_tuser == OP_EVAL);

  // Scan position: row during the single walk, slot during the compound chain
  always_comb begin
    scan_next = scan;
    if (scan_single) begin
      scan_next = single_last ? '0 : scan + SCAN_W'(1);
    end else if (scan_compound) begin
      scan_next = compound_last ? '0 : scan + SCAN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan  <= '0;
    end else begin
      state <= state_next;
      scan  <= scan_next;
    end
  end

  // Distances held for the whole evaluation
  always_ff @(posedge clk) begin
    if (eval_start) begin
      dist0 <= DIST_BITS'(dist_sensor0);
      dist1 <= DIST_BITS'(dist_sensor1);
      dist2 <= DIST_BITS'(dist_sensor2);
    end
  end

  // Table write decode
  always_comb begin
    wr_single   = accept && (s_axis_tuser == OP_WR_SINGLE) &&
                  (int'(entry_index) < SINGLE_EVENTS);
    wr_compound = accept && (s_axis_tuser == OP_WR_COMPOUND) &&
                  (int'(entry_index) >= SINGLE_EVENTS) &&
                  (int'(entry_index) < TOTAL_EVENTS);
    wr_lane     = entry_index[LANE_W-1:0];
    wr_row      = ROW_W'(entry_index >> LANE_W);
    wr_slot     = CMP_W'(int'(entry_index) - SINGLE_EVENTS);
    wr_single_entry.en     = entry_enable;
    wr_single_entry.sensor = entry_sensor;
    wr_single_entry.lo     = DIST_BITS'(min_mm);
    wr_single_entry.hi     = DIST_BITS'(max_mm);
    wr_cmp_entry.en        = entry_enable;
    wr_cmp_entry.first     = first_event;
    wr_cmp_entry.second    = second_event;
  end

  // Single-event lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    dep_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_single && (wr_lane == LANE_W'(l))),
      .wr_row   (wr_row),
      .wr_entry (wr_single_entry),
      .rd_row   (scan[ROW_W-1:0]),
      .dist0    (dist0),
      .dist1    (dist1),
      .dist2    (dist2),
      .hit      (lane_hit[l])
    );
  end

  dep_compound u_compound (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_compound),
    .wr_slot  (wr_slot),
    .wr_entry (wr_cmp_entry),
    .rd_slot  (scan[CMP_W-1:0]),
    .flags    (flags),
    .hit      (cmp_hit)
  );

  // Merge controls
  always_comb begin
    mctl.clear       = eval_start;
    mctl.single_en   = scan_single;
    mctl.row         = scan[ROW_W-1:0];
    mctl.compound_en = scan_compound;
    mctl.slot        = scan[CMP_W-1:0];
  end

  dep_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mctl),
    .lane_hit (lane_hit),
    .cmp_hit  (cmp_hit),
    .flags    (flags),
    .any      (any),
    .top      (top)
  );

  // Output register
  assign flags_pad = PAD_W'(flags);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= OUT_W'({IDX_W'(top), any, flags_pad[STATUS_W-1:0]});
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// File: src/dep_checker.sv
// Port-level checks for the distance event priority evaluator, bound to the top level.
module dep_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [dep_pkg::IN_W-1:0]  s_axis_tdata,
  input logic [1:0]                s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [dep_pkg::OUT_W-1:0] m_axis_tdata
);
  import dep_pkg::*;

  // A stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // any_active agrees with the status flags; top is zero when nothing is set
  a_any_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[STATUS_W] == (m_axis_tdata[STATUS_W-1:0] != '0)) &&
      (m_axis_tdata[STATUS_W] || (m_axis_tdata[STATUS_W+IDX_W:STATUS_W+1] == '0)))
    else $error("any_active or top_event inconsistent with status");

  // top_event names the highest set flag
  a_top_highest: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[STATUS_W] |->
      ((m_axis_tdata[STATUS_W-1:0] >> m_axis_tdata[STATUS_W+IDX_W:STATUS_W+1]) ==
       STATUS_W'(1)))
    else $error("top_event is not the highest true event");

  // An evaluate beat busies the input side on the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_EVAL) |=> !s_axis_tready)
    else $error("input accepted during an evaluation");

endmodule

bind distance_event_priority_evaluator dep_checker u_dep_checker (.*);

// File: tb/distance_event_priority_evaluator_tb.sv
// Self-checking testbench for the distance event priority evaluator.
`timescale 1ns / 100ps

module distance_event_priority_evaluator_tb;
  import dep_pkg::*;

  // Operation code the block must drop
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 2000;

  // Input beat, first field in the lowest bits
  typedef struct packed {
    logic [MM_W-1:0]  dist2;
    logic [MM_W-1:0]  dist1;
    logic [MM_W-1:0]  dist0;
    logic [IDX_W-1:0] second_ev;
    logic [IDX_W-1:0] first_ev;
    logic [MM_W-1:0]  max_mm;
    logic [MM_W-1:0]  min_mm;
    logic [1:0]       sensor;
    logic             enable;
    logic [IDX_W-1:0] entry_idx;
  } in_beat_t;

  // Output beat, first field in the lowest bits
  typedef struct packed {
    logic [IDX_W-1:0]    top_event;
    logic                any_active;
    logic [STATUS_W-1:0] status_bits;
  } result_t;

  // Event table mirror and queue of pending evaluation results
  class event_scoreboard;
    single_entry_t   singles[SINGLE_EVENTS];
    compound_entry_t compounds[COMPOUND_EVENTS];
    logic [TOTAL_EVENTS-1:0] flags;
    result_t pending_q[$];
    int errors;

    function new();
      foreach (singles[i]) singles[i] = '0;
      foreach (compounds[i]) compounds[i] = '0;
      flags  = '0;
      errors = 0;
    endfunction

    // Update the mirror for an accepted beat; evaluations queue a result
    function void note_beat(logic [1:0] op, in_beat_t b);
      result_t r;
      logic [MM_W-1:0] d;
      logic hit, fa, fb;
      case (op)
        OP_WR_SINGLE: begin
          if (b.entry_idx < SINGLE_EVENTS) begin
            singles[b.entry_idx].en     = b.enable;
            singles[b.entry_idx].sensor = b.sensor;
            singles[b.entry_idx].lo     = b.min_mm;
            singles[b.entry_idx].hi     = b.max_mm;
          end
        end
        OP_WR_COMPOUND: begin
          if (b.entry_idx >= SINGLE_EVENTS && b.entry_idx < TOTAL_EVENTS) begin
            compounds[b.entry_idx - SINGLE_EVENTS].en     = b.enable;
            compounds[b.entry_idx - SINGLE_EVENTS].first  = b.first_ev;
            compounds[b.entry_idx - SINGLE_EVENTS].second = b.second_ev;
          end
        end
        OP_EVAL: begin
          // singles on the fresh distances
          for (int e = 0; e < SINGLE_EVENTS; e++) begin
            hit = 1'b1;
            case (singles[e].sensor)
              SENSOR_0: d = b.dist0;
              SENSOR_1: d = b.dist1;
              SENSOR_2: d = b.dist2;
              default: begin
                d   = '0;
                hit = 1'b0;
              end
            endcase
            flags[e] = singles[e].en && hit && d >= singles[e].lo && d <= singles[e].hi;
          end
          // compounds in rising order, in place: higher ones still hold last status
          for (int c = 0; c < COMPOUND_EVENTS; c++) begin
            fa = (compounds[c].first < TOTAL_EVENTS) ? flags[compounds[c].first] : 1'b0;
            fb = (compounds[c].second < TOTAL_EVENTS) ? flags[compounds[c].second] : 1'b0;
            flags[SINGLE_EVENTS + c] = compounds[c].en && fa && fb;
          end
          r.status_bits = flags;
          r.any_active  = |flags;
          r.top_event   = '0;
          for (int e = 0; e < TOTAL_EVENTS; e++)
            if (flags[e]) r.top_event = IDX_W'(e);
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compare an accepted output beat with the oldest pending result
    function void check_result(logic [OUT_W-1:0] data);
      result_t got, want;
      got = data[$bits(result_t)-1:0];
      if (pending_q.size() == 0) begin
        $error("unexpected output beat %h", data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status_bits !== want.status_bits) begin
        $error("status_bits: expected %h, got %h", want.status_bits, got.status_bits);
        errors++;
      end
      if (got.any_active !== want.any_active) begin
        $error("any_active: expected %0d, got %0d", want.any_active, got.any_active);
        errors++;
      end
      if (got.top_event !== want.top_event) begin
        $error("top_event: expected %0d, got %0d", want.top_event, got.top_event);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = OP_WR_SINGLE;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;

  event_scoreboard sb = new();
  bit steady = 1'b0;   // no idling on either side while set
  int hot[3];          // distances that table ranges cluster around

  distance_event_priority_evaluator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure
  always @(negedge clk)
    m_axis_tready <= steady || ($urandom_range(99) >= 17);

  // Result monitor
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  function automatic logic [MM_W-1:0] clamp_mm(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[MM_W-1:0];
  endfunction

  function automatic in_beat_t noise_beat();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_beat_t)-1:0];
  endfunction

  // Drive one beat starting at a falling edge; returns at the falling edge after accept
  task automatic send_beat(logic [1:0] op, in_beat_t b);
    if (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(b);
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(op, b);
    @(negedge clk);
  endtask

  task automatic write_single(logic [IDX_W-1:0] idx, logic en, logic [1:0] sensor,
                              logic [MM_W-1:0] lo, logic [MM_W-1:0] hi);
    in_beat_t b;
    b = noise_beat();
    b.entry_idx = idx;
    b.enable    = en;
    b.sensor    = sensor;
    b.min_mm    = lo;
    b.max_mm    = hi;
    send_beat(OP_WR_SINGLE, b);
  endtask

  task automatic write_compound(logic [IDX_W-1:0] idx, logic en, logic [IDX_W-1:0] ev_a,
                                logic [IDX_W-1:0] ev_b);
    in_beat_t b;
    b = noise_beat();
    b.entry_idx = idx;
    b.enable    = en;
    b.first_ev  = ev_a;
    b.second_ev = ev_b;
    send_beat(OP_WR_COMPOUND, b);
  endtask

  task automatic evaluate(logic [MM_W-1:0] d0, logic [MM_W-1:0] d1, logic [MM_W-1:0] d2);
    in_beat_t b;
    b = noise_beat();
    b.dist0 = d0;
    b.dist1 = d1;
    b.dist2 = d2;
    send_beat(OP_EVAL, b);
  endtask

  // Stimulus
  initial begin
    int issued, kind, s;
    logic [MM_W-1:0] lo, hi;
    logic [MM_W-1:0] d[3];

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, extremes, wrong tables, dropped op, compound chaining
    evaluate('0, '0, '0);
    write_single(0, 1'b1, SENSOR_0, 16'h0000, 16'h0000);
    write_single(15, 1'b1, SENSOR_2, 16'hFFFF, 16'hFFFF);
    write_single(5, 1'b1, 2'd3, 16'h0000, 16'hFFFF);       // sensor three never matches
    write_single(6, 1'b1, SENSOR_1, 16'd500, 16'd100);     // empty range
    write_single(7, 1'b1, SENSOR_1, 16'h0000, 16'hFFFF);
    write_single(16, 1'b1, SENSOR_0, 16'h0000, 16'hFFFF);  // compound slot, dropped
    write_single(31, 1'b1, SENSOR_0, 16'h0000, 16'hFFFF);  // out of range, dropped
    write_compound(16, 1'b1, 5'd0, 5'd15);
    write_compound(17, 1'b1, 5'd18, 5'd7);                 // reads stale status of 18
    write_compound(18, 1'b1, 5'd16, 5'd7);
    write_compound(19, 1'b1, 5'd31, 5'd7);                 // out of range operand
    write_compound(3, 1'b1, 5'd0, 5'd0);                   // single slot, dropped
    write_compound(31, 1'b1, 5'd0, 5'd0);                  // dropped
    send_beat(OP_UNUSED, noise_beat());
    evaluate(16'd0, 16'd300, 16'hFFFF);
    evaluate(16'd0, 16'd300, 16'hFFFF);
    evaluate(16'hFFFF, 16'hFFFF, 16'd0);
    write_compound(19, 1'b1, 5'd19, 5'd19);                // self reference
    write_compound(17, 1'b0, 5'd18, 5'd7);
    evaluate(16'd0, 16'd65535, 16'hFFFF);
    write_single(0, 1'b0, SENSOR_0, 16'h0000, 16'hFFFF);
    evaluate(16'd0, 16'd1, 16'hFFFF);

    // Random: mostly well-formed table loads and evaluations near the ranges
    foreach (hot[i]) hot[i] = $urandom_range(0, 65535);
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      steady = (issued >= 900 && issued < 1200);
      if ($urandom_range(199) == 0) hot[$urandom_range(0, 2)] = $urandom_range(0, 65535);
      kind = $urandom_range(99);
      if (kind < 35) begin
        for (int i = 0; i < 3; i++)
          d[i] = ($urandom_range(9) < 7) ? clamp_mm(hot[i] + int'($urandom_range(0, 200)) - 100)
                                        : 16'($urandom);
        evaluate(d[0], d[1], d[2]);
        issued++;
      end else if (kind < 65) begin
        s = ($urandom_range(19) == 0) ? 3 : $urandom_range(0, 2);
        if ($urandom_range(9) < 8) begin
          lo = clamp_mm(hot[s % 3] - int'($urandom_range(0, 150)));
          hi = clamp_mm(hot[s % 3] + int'($urandom_range(0, 150)));
        end else begin
          lo = MM_W'($urandom);
          hi = MM_W'($urandom);
        end
        write_single(IDX_W'($urandom_range(0, SINGLE_EVENTS - 1)), $urandom_range(9) != 0,
                     s[1:0], lo, hi);
        issued++;
      end else if (kind < 88) begin
        write_compound(IDX_W'($urandom_range(SINGLE_EVENTS, TOTAL_EVENTS - 1)),
                       $urandom_range(9) != 0,
                       IDX_W'(($urandom_range(9) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, TOTAL_EVENTS - 1)),
                       IDX_W'(($urandom_range(9) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, TOTAL_EVENTS - 1)));
        issued++;
      end else begin
        // noise: any operation with any index, counted only when it is not dropped
        in_beat_t b;
        logic [1:0] op;
        b  = noise_beat();
        op = 2'($urandom_range(0, 3));
        send_beat(op, b);
        if (op == OP_EVAL || (op == OP_WR_SINGLE && b.entry_idx < SINGLE_EVENTS) ||
            (op == OP_WR_COMPOUND && b.entry_idx >= SINGLE_EVENTS &&
             b.entry_idx < TOTAL_EVENTS))
          issued++;
      end
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the block's latency to expose stray beats
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("distance_event_priority_evaluator regression: pass");
    else
      $display("distance_event_priority_evaluator regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("distance_event_priority_evaluator regression: fail");
    $finish;
  end

endmodule

// File: distance_event_priority_evaluator.f
src/dep_pkg.sv
src/dep_lane.sv
src/dep_compound.sv
src/dep_merge.sv
src/distance_event_priority_evaluator.sv
src/dep_checker.sv
tb/distance_event_priority_evaluator_tb.sv
